// ===== rtl/core/pfa_pkg.sv =====
package pfa_pkg;

	// Timing constants. TIME_ONE is one second in timer units. TIME_ONE,
	// FADE_TIME and WAVE_ENTRIES are powers of two, with
	// TIME_ONE >= 65536 and TIME_ONE >= WAVE_ENTRIES.
	localparam int unsigned TIME_ONE       = 65536;
	localparam int unsigned FADE_TIME      = 16384;
	localparam int unsigned WAVE_ENTRIES   = 1024;

	localparam int unsigned ELAPSED_W      = 16;
	localparam int unsigned ALPHA_W        = 8;
	localparam int unsigned TIMER_W        = $clog2(TIME_ONE + (1 << ELAPSED_W));
	localparam int unsigned FADE_TIMER_MAX = 131071;
	localparam int unsigned WAVE_AW        = $clog2(WAVE_ENTRIES);
	localparam int unsigned IDX_SHIFT      = $clog2(TIME_ONE / WAVE_ENTRIES);
	localparam int unsigned FADE_SHIFT     = $clog2(FADE_TIME);

	// Q30 fixed point for the table build
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] N64     = 64'(WAVE_ENTRIES);

	typedef enum logic [1:0] {
		ST_INACTIVE = 2'd0,
		ST_PULSE    = 2'd1,
		ST_FADE     = 2'd2,
		ST_EXIT     = 2'd3
	} run_state_t;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2
	} mode_t;

	// where the alpha of an item comes from
	typedef enum logic [1:0] {
		SRC_HOLD = 2'd0,
		SRC_ZERO = 2'd1,
		SRC_WAVE = 2'd2,
		SRC_FADE = 2'd3
	} level_src_t;

	// floor(255 * sin^2(pi * p / N)), sine by truncated Taylor series in Q30
	function automatic logic [ALPHA_W-1:0] wave_entry(input int unsigned p);
		logic [63:0] pp;
		logic [63:0] m;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] s2;
		logic [63:0] v;
		pp = 64'(p);
		m  = (pp <= N64 - pp) ? pp : N64 - pp;
		a  = (m * PI_Q30) / N64;
		a2 = (a * a) >> 30;
		t  = Q30_ONE - a2 / 64'd110;
		t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
		s  = (a * t) >> 30;
		s2 = (s * s) >> 30;
		v  = (64'd255 * s2) >> 30;
		return (v > 64'd255) ? ALPHA_W'(255) : v[ALPHA_W-1:0];
	endfunction

endpackage

// ===== rtl/core/pfa_wave_rom.sv =====
module pfa_wave_rom
	import pfa_pkg::*;
(
	input  logic               clk,
	input  logic               rd_en,
	input  logic [WAVE_AW-1:0] rd_addr,
	output logic [ALPHA_W-1:0] rd_data
);

	// raised-cosine shape, fixed at elaboration
	logic [ALPHA_W-1:0] rom [WAVE_ENTRIES];

	for (genvar g = 0; g < WAVE_ENTRIES; g++) begin : g_rom
		assign rom[g] = wave_entry(g);
	end

	logic [ALPHA_W-1:0] data_s1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_s1 <= rom[rd_addr];
		end
	end

	assign rd_data = data_s1;

endmodule

// ===== rtl/core/pulse_fade_alpha_generator.sv =====
// Breathing / fade-out alpha generator. Items arrive on the item channel:
// mode 0 is a time tick carrying elapsed time in 1/65536 s, mode 1 starts a
// raised-cosine pulse with a 1 s period, mode 2 stops it into a linear fade
// that lasts FADE_TIME; mode 3 is ignored. Every item gives exactly one result
// (alpha 0..255 and the phase: 0 inactive, 1 pulsing, 2 fading, 3 exit), in
// order. The block takes one item per clock while its results are taken;
// the timer and phase update at acceptance, and the wave ROM read and the
// fade level land in the output register on the same edge. A new item is
// taken whenever the output register is empty or its result is being taken
// in that cycle. No start-up sweep is needed; the table is a ROM.
module pulse_fade_alpha_generator
	import pfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         mode,
	input  logic [ELAPSED_W-1:0] elapsed,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [ALPHA_W-1:0] alpha,
	output logic [1:0]         phase_state
);

	localparam int unsigned REM_W  = FADE_SHIFT + 1;
	localparam int unsigned PROD_W = REM_W + ALPHA_W;

	// architectural state
	run_state_t          run_state_q;
	logic [TIMER_W-1:0]  timer_q;
	logic [ALPHA_W-1:0]  level_q;	// alpha of the last delivered item

	// output register
	logic                result_valid_s1;
	level_src_t          src_s1;
	run_state_t          state_s1;
	logic [ALPHA_W-1:0]  fade_lvl_s1;

	logic                item_acc;
	logic                result_acc;

	run_state_t          state_d;
	logic [TIMER_W-1:0]  timer_d;
	level_src_t          src_d;

	logic [TIMER_W:0]    sum;
	logic [TIMER_W-1:0]  pulse_t;
	logic [TIMER_W-1:0]  fade_t;
	logic                fade_done;
	logic [REM_W-1:0]    fade_rem;
	logic [PROD_W-1:0]   fade_prod;
	logic [ALPHA_W-1:0]  fade_lvl;
	logic [WAVE_AW-1:0]  wave_addr;
	logic [ALPHA_W-1:0]  wave_lvl;

	// Single output stage: it frees up in the same cycle its result goes.
	assign item_ready = !result_valid_s1 || result_ready;
	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid_s1 && result_ready;

	// Timer arithmetic for a tick. In pulse mode the timer never exceeds
	// TIME_ONE and a tick adds under 2^16, so one subtract does the wrap.
	// Exactly TIME_ONE is kept, not wrapped to zero.
	assign sum     = {1'b0, timer_q} + (TIMER_W + 1)'(elapsed);
	assign pulse_t = (sum > (TIMER_W + 1)'(TIME_ONE)) ?
	                 TIMER_W'(sum - (TIMER_W + 1)'(TIME_ONE)) : sum[TIMER_W-1:0];

	// Table index: timer scaled to the table, a full period folds back to 0.
	assign wave_addr = WAVE_AW'(pulse_t >> IDX_SHIFT);

	// Fade timer saturates; level ramps down linearly to zero at FADE_TIME.
	assign fade_t    = (sum > (TIMER_W + 1)'(FADE_TIMER_MAX)) ?
	                   TIMER_W'(FADE_TIMER_MAX) : sum[TIMER_W-1:0];
	assign fade_done = (fade_t >= TIMER_W'(FADE_TIME));
	assign fade_rem  = REM_W'(TIMER_W'(FADE_TIME) - fade_t);	// only used when not done
	assign fade_prod = (PROD_W'(fade_rem) << ALPHA_W) - PROD_W'(fade_rem);	// x255
	assign fade_lvl  = ALPHA_W'(fade_prod >> FADE_SHIFT);

	// Next phase and timer
	always_comb begin
		state_d = run_state_q;
		timer_d = timer_q;
		unique case (mode)
			MODE_TICK: begin
				unique case (run_state_q)
					ST_PULSE: begin
						timer_d = pulse_t;
					end
					ST_FADE: begin
						timer_d = fade_t;
						if (fade_done) begin
							state_d = ST_EXIT;
						end
					end
					ST_EXIT: begin
						state_d = ST_INACTIVE;
					end
					ST_INACTIVE: begin
					end
				endcase
			end
			MODE_START: begin
				state_d = ST_PULSE;
				timer_d = '0;
			end
			MODE_STOP: begin
				// stop only bites on an active pulse or a running fade
				if (run_state_q == ST_PULSE || run_state_q == ST_FADE) begin
					state_d = ST_FADE;
					timer_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Where this item's alpha comes from
	always_comb begin
		src_d = SRC_HOLD;
		unique case (mode)
			MODE_TICK: begin
				unique case (run_state_q)
					ST_PULSE:    src_d = SRC_WAVE;
					ST_FADE:     src_d = fade_done ? SRC_ZERO : SRC_FADE;
					ST_EXIT:     src_d = SRC_ZERO;
					ST_INACTIVE: src_d = SRC_ZERO;
				endcase
			end
			MODE_START: src_d = SRC_ZERO;
			default:    src_d = SRC_HOLD;	// stop keeps the level until the next tick
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_state_q <= ST_INACTIVE;
			timer_q     <= '0;
		end else if (item_acc) begin
			run_state_q <= state_d;
			timer_q     <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s1 <= 1'b0;
			src_s1          <= SRC_ZERO;
			state_s1        <= ST_INACTIVE;
		end else if (item_acc) begin
			result_valid_s1 <= 1'b1;
			src_s1          <= src_d;
			state_s1        <= state_d;
		end else if (result_acc) begin
			result_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			fade_lvl_s1 <= fade_lvl;
		end
	end

	pfa_wave_rom u_wave_rom (
		.clk     (clk),
		.rd_en   (item_acc),
		.rd_addr (wave_addr),
		.rd_data (wave_lvl)
	);

	// Items leave in order, so level_q is always the previous item's alpha.
	always_comb begin
		alpha = level_q;
		case (src_s1)
			SRC_HOLD: alpha = level_q;
			SRC_ZERO: alpha = '0;
			SRC_WAVE: alpha = wave_lvl;
			SRC_FADE: alpha = fade_lvl_s1;
			default:  alpha = level_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (result_acc) begin
			level_q <= alpha;
		end
	end

	assign result_valid = result_valid_s1;
	assign phase_state  = state_s1;

endmodule

// ===== rtl/core/pfa_checker.sv =====
module pfa_checker
	import pfa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic [1:0]         mode,
	input logic               result_valid,
	input logic               result_ready,
	input logic [ALPHA_W-1:0] alpha,
	input logic [1:0]         phase_state
);

	// a waiting result holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(alpha) &&
		$stable(phase_state))
	else $error("result changed while stalled");

	// only one item in flight: a stalled result blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
	else $error("item taken while output full");

	// inactive and exit always show zero alpha
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (phase_state == ST_INACTIVE || phase_state == ST_EXIT)
		|-> alpha == '0)
	else $error("non-zero alpha while idle");

	// a start gives a pulsing result at zero in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && mode == MODE_START |=>
		result_valid && phase_state == ST_PULSE && alpha == '0)
	else $error("start not reflected");

endmodule

bind pulse_fade_alpha_generator pfa_checker u_pfa_checker (.*);
